// ===== rtl/md5sh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types and constants of the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned QDEPTH = 4;

    // one classified beat between front and back
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_beat;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== rtl/md5_stream_hasher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher_unit
// MD5 digest of a byte stream, at most one byte per input beat.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   input   | i_valid / o_ready    | i_msg_byte, i_byte_present,
//           |                      | i_end_of_message
//   output  | o_valid / i_ready    | o_digest_a .. o_digest_d
//
// A byte beat is taken while the back end is idle; the 64th byte of a block
// starts a compression (the rounds, then a fold) in the shared round unit.
// The final beat leads to the pad, length, compression and digest states; a
// full last block is compressed before the pad, and a pad that spills into a
// second block is compressed before the length. A four-entry queue lets the
// input keep moving while the round unit works. Reset is synchronous and
// restores the initial vector. A stalled digest holds the back end at the
// next digest; the queue then fills and drops o_ready.
// ----------------------------------------------------------------------------
module md5_stream_hasher_unit import md5sh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_a,
    output logic [31:0] o_digest_b,
    output logic [31:0] o_digest_c,
    output logic [31:0] o_digest_d
);

    logic  w_q_valid, w_q_ready;
    t_beat w_q_beat;

    md5sh_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_msg_byte       (i_msg_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_q_valid        (w_q_valid),
        .i_q_ready        (w_q_ready),
        .o_q_beat         (w_q_beat)
    );

    md5sh_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .o_q_ready  (w_q_ready),
        .i_q_beat   (w_q_beat),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_digest_a (o_digest_a),
        .o_digest_b (o_digest_b),
        .o_digest_c (o_digest_c),
        .o_digest_d (o_digest_d)
    );

endmodule

// ===== rtl/md5sh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_front
// Accepts input beats, drops empty non-final beats, and queues the rest.
// ----------------------------------------------------------------------------
module md5sh_front import md5sh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_q_valid,
    input  logic        i_q_ready,
    output t_beat       o_q_beat
);

    localparam int unsigned AW = $clog2(QDEPTH);

    t_beat            r_mem [QDEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop, w_keep;

    // keep only beats that carry a byte or end a message
    assign o_ready   = (r_cnt != (AW+1)'(QDEPTH));
    assign w_keep    = i_byte_present | i_end_of_message;
    assign w_push    = i_valid & o_ready & w_keep;
    assign o_q_valid = (r_cnt != '0);
    assign w_pop     = o_q_valid & i_q_ready;
    assign o_q_beat  = r_mem[r_rd];

    // write queue entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= '{data: i_msg_byte, present: i_byte_present,
                             last: i_end_of_message};
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

endmodule

// ===== rtl/md5sh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_back
// Packs bytes, pads, runs one MD5 round per cycle and emits the digest.
// ----------------------------------------------------------------------------
module md5sh_back import md5sh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_beat       i_q_beat,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_a,
    output logic [31:0] o_digest_b,
    output logic [31:0] o_digest_c,
    output logic [31:0] o_digest_d
);

    t_state       r_state, n_state;
    logic [31:0]  r_blk [16];
    logic [31:0]  r_h [4];
    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [63:0]  r_cnt;
    logic [5:0]   r_pos;
    logic [5:0]   r_rnd;
    logic         r_final;
    logic         r_extra;
    logic         r_len;
    logic         r_ovld;
    logic [31:0]  r_oa, r_ob, r_oc, r_od;

    logic         w_take;
    logic [3:0]   w_g;
    logic [31:0]  w_f, w_sum, w_rot;
    logic [4:0]   w_s;
    logic [63:0]  w_bits;

    // round function
    always_comb begin
        unique case (r_rnd[5:4])
            2'd0: begin
                w_f = (r_b & r_c) | (~r_b & r_d);
                w_g = r_rnd[3:0];
            end
            2'd1: begin
                w_f = (r_b & r_d) | (r_c & ~r_d);
                w_g = 4'(5 * r_rnd[3:0] + 1);
            end
            2'd2: begin
                w_f = r_b ^ r_c ^ r_d;
                w_g = 4'(3 * r_rnd[3:0] + 5);
            end
            default: begin
                w_f = r_c ^ (r_b | ~r_d);
                w_g = 4'(7 * r_rnd[3:0]);
            end
        endcase
        w_s   = rot_amt(r_rnd);
        w_sum = w_f + r_a + round_k(r_rnd) + r_blk[w_g];
        w_rot = (w_sum << w_s) | (w_sum >> (6'd32 - {1'b0, w_s}));
    end

    assign w_bits    = {r_cnt[60:0], 3'b000};
    assign o_q_ready = (r_state == ST_IDLE);
    assign w_take    = i_q_valid & o_q_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_q_beat.present && r_pos == 6'd63) n_state = ST_ROUND;
                    else if (i_q_beat.last) n_state = ST_PAD;
                end
            end
            ST_PAD:   n_state = r_extra ? ST_ROUND : ST_LEN;
            ST_LEN:   n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 6'd63) n_state = ST_FOLD;
            ST_FOLD: begin
                if (r_extra)               n_state = ST_LEN;
                else if (r_final && r_len) n_state = ST_OUT;
                else if (r_final)          n_state = ST_PAD;
                else                       n_state = ST_IDLE;
            end
            ST_OUT:   if (!r_ovld) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_rnd   <= '0;
            r_final <= 1'b0;
            r_extra <= 1'b0;
            r_len   <= 1'b0;
            r_ovld  <= 1'b0;
            r_h[0]  <= IV_A;
            r_h[1]  <= IV_B;
            r_h[2]  <= IV_C;
            r_h[3]  <= IV_D;
        end else begin
            r_state <= n_state;
            if (r_ovld && i_ready) r_ovld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_final <= i_q_beat.last;
                        if (i_q_beat.present) begin
                            r_cnt <= r_cnt + 64'd1;
                            r_pos <= r_pos + 6'd1;
                        end
                    end
                end
                ST_LEN: r_len <= 1'b1;
                ST_ROUND: r_rnd <= r_rnd + 6'd1;
                ST_FOLD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                end
                ST_OUT: begin
                    if (!r_ovld) begin
                        r_ovld <= 1'b1;
                        r_oa   <= r_h[0];
                        r_ob   <= r_h[1];
                        r_oc   <= r_h[2];
                        r_od   <= r_h[3];
                        r_h[0] <= IV_A;
                        r_h[1] <= IV_B;
                        r_h[2] <= IV_C;
                        r_h[3] <= IV_D;
                        r_cnt  <= '0;
                        r_pos  <= '0;
                        r_final <= 1'b0;
                        r_len  <= 1'b0;
                    end
                end
                default: ;
            endcase
            // flag a two-block pad when the fill is 56 or more at the end
            if (r_state == ST_IDLE && n_state == ST_PAD)
                r_extra <= ((i_q_beat.present ? r_pos + 6'd1 : r_pos) >= 6'd56);
            else if (r_state == ST_FOLD)
                r_extra <= 1'b0;
        end
    end

    // block buffer and working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && i_q_beat.present) begin
                    r_blk[r_pos[5:2]][8*r_pos[1:0] +: 8] <= i_q_beat.data;
                end
                r_a <= r_h[0];
                r_b <= r_h[1];
                r_c <= r_h[2];
                r_d <= r_h[3];
            end
            ST_PAD: begin
                // clear past the fill, mark the pad byte
                for (int w = 0; w < 16; w++) begin
                    for (int y = 0; y < 4; y++) begin
                        if (6'(4 * w + y) == r_pos)
                            r_blk[w][8*y +: 8] <= PAD_BYTE;
                        else if (6'(4 * w + y) > r_pos || r_pos == 6'd0 && w + y > 0)
                            r_blk[w][8*y +: 8] <= 8'h00;
                    end
                end
                r_a <= r_h[0];
                r_b <= r_h[1];
                r_c <= r_h[2];
                r_d <= r_h[3];
            end
            ST_LEN: begin
                r_blk[14] <= w_bits[31:0];
                r_blk[15] <= w_bits[63:32];
                r_a <= r_h[0];
                r_b <= r_h[1];
                r_c <= r_h[2];
                r_d <= r_h[3];
            end
            ST_ROUND: begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= r_b + w_rot;
            end
            ST_FOLD: begin
                // second pad block is all zeros before the length
                if (r_extra) begin
                    for (int w = 0; w < 16; w++) r_blk[w] <= '0;
                end
                r_a <= r_h[0] + r_a;
                r_b <= r_h[1] + r_b;
                r_c <= r_h[2] + r_c;
                r_d <= r_h[3] + r_d;
            end
            default: ;
        endcase
    end

    assign o_valid    = r_ovld;
    assign o_digest_a = r_oa;
    assign o_digest_b = r_ob;
    assign o_digest_c = r_oc;
    assign o_digest_d = r_od;

endmodule
